### rtl/tgr_pkg.sv
// tgr_pkg: shared types and constants of the triangle gradient rows unit
// word layouts of both channels, the front-to-back queue entry, fixed widths
// no dependencies
`default_nettype none

package tgr_pkg;

	localparam int FRAC_BITS_DEF   = 16;
	localparam int COUNT_WIDTH_DEF = 32;

	localparam int VEC_W  = 33;   // vertex difference
	localparam int MUL_W  = 35;   // multiplier operand
	localparam int PROD_W = 2 * MUL_W;
	localparam int LEN_W  = 34;   // frame length
	localparam int RAD_W  = 2 * LEN_W;
	localparam int DEN_W  = 68;   // l * y
	localparam int ACC_W  = 100;

	localparam logic signed [63:0] SAT_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam logic signed [63:0] SAT_MIN = 64'sh8000_0000_0000_0000;

	typedef struct packed {
		logic signed [31:0] ax;
		logic signed [31:0] ay;
		logic signed [31:0] az;
		logic signed [31:0] bx;
		logic signed [31:0] by_coord;
		logic signed [31:0] bz;
		logic signed [31:0] cx;
		logic signed [31:0] cy;
		logic signed [31:0] cz;
		logic signed [31:0] prior_a;
		logic signed [31:0] prior_b;
		logic signed [31:0] prior_c;
	} tgr_in_t;

	typedef struct packed {
		logic               axis;
		logic signed [63:0] grad_a;
		logic signed [63:0] grad_b;
		logic signed [63:0] grad_c;
		logic signed [63:0] row_target;
		logic [62:0]        tri_area;
		logic               degenerate;
		logic               last;
		logic [31:0]        valid_total;
		logic [31:0]        skipped_total;
	} tgr_out_t;

	typedef struct packed {
		logic signed [VEC_W-1:0] e0;
		logic signed [VEC_W-1:0] e1;
		logic signed [VEC_W-1:0] e2;
		logic signed [VEC_W-1:0] f0;
		logic signed [VEC_W-1:0] f1;
		logic signed [VEC_W-1:0] f2;
		logic signed [31:0]      p0;
		logic signed [31:0]      p1;
		logic signed [31:0]      p2;
	} tgr_ent_t;

endpackage

`default_nettype wire

### rtl/tgr_front.sv
// tgr_front: accepts triangle words, forms edge vectors, two-entry queue
// depends on tgr_pkg
`default_nettype none

module tgr_front import tgr_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_stall,
	input  wire tgr_in_t  in_word,
	output logic          ent_valid,
	output tgr_ent_t      ent,
	input  wire logic     pop
);

	tgr_ent_t   q_mem [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       push;
	tgr_ent_t   new_ent;

	assign in_stall  = (count_q == 2'd2);
	assign push      = in_valid && !in_stall;
	assign ent_valid = (count_q != 2'd0);
	assign ent       = q_mem[rd_ptr_q];

	always_comb begin
		new_ent.e0 = {in_word.bx[31], in_word.bx} - {in_word.ax[31], in_word.ax};
		new_ent.e1 = {in_word.by_coord[31], in_word.by_coord} - {in_word.ay[31], in_word.ay};
		new_ent.e2 = {in_word.bz[31], in_word.bz} - {in_word.az[31], in_word.az};
		new_ent.f0 = {in_word.cx[31], in_word.cx} - {in_word.ax[31], in_word.ax};
		new_ent.f1 = {in_word.cy[31], in_word.cy} - {in_word.ay[31], in_word.ay};
		new_ent.f2 = {in_word.cz[31], in_word.cz} - {in_word.az[31], in_word.az};
		new_ent.p0 = in_word.prior_a;
		new_ent.p1 = in_word.prior_b;
		new_ent.p2 = in_word.prior_c;
	end

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem[wr_ptr_q] <= new_ent;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

`default_nettype wire

### rtl/tgr_div.sv
// tgr_div: radix-2 restoring unsigned divider, one quotient bit per cycle
// depends on tgr_pkg
`default_nettype none

module tgr_div import tgr_pkg::*; #(
	parameter int DW = 83
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [DW-1:0]    dividend,
	input  wire logic [DEN_W-1:0] divisor,
	output logic                  done,
	output logic [DW-1:0]         quo
);

	localparam int CW = $clog2(DW + 1);

	logic [DW-1:0]    num_q;
	logic [DW-1:0]    quo_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] dvs_q;
	logic [CW-1:0]    cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DEN_W:0]   rem_sh;
	logic [DEN_W:0]   rem_dif;
	logic             fits;

	assign rem_sh  = {rem_q, num_q[DW-1]};
	assign rem_dif = rem_sh - {1'b0, dvs_q};
	assign fits    = (rem_sh >= {1'b0, dvs_q});
	assign done    = done_q;
	assign quo     = quo_q;

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[DW-2:0], 1'b0};
			rem_q <= fits ? rem_dif[DEN_W-1:0] : rem_sh[DEN_W-1:0];
			quo_q <= {quo_q[DW-2:0], fits};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(DW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule

`default_nettype wire

### rtl/tgr_sqrt.sv
// tgr_sqrt: digit-by-digit integer square root, one root bit per cycle
// depends on tgr_pkg
`default_nettype none

module tgr_sqrt import tgr_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [RAD_W-1:0] rad,
	output logic                  done,
	output logic [LEN_W-1:0]      root
);

	localparam int CW = $clog2(LEN_W + 1);

	logic [RAD_W-1:0] rad_q;
	logic [LEN_W:0]   rem_q;
	logic [LEN_W-1:0] root_q;
	logic [CW-1:0]    cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [LEN_W+2:0] rem_sh;
	logic [LEN_W+2:0] trial;
	logic [LEN_W+2:0] rem_dif;
	logic             fits;

	assign rem_sh  = {rem_q, rad_q[RAD_W-1:RAD_W-2]};
	assign trial   = {1'b0, root_q, 2'b01};
	assign rem_dif = rem_sh - trial;
	assign fits    = (rem_sh >= trial);
	assign done    = done_q;
	assign root    = root_q;

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= rad;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q  <= {rad_q[RAD_W-3:0], 2'b00};
			rem_q  <= fits ? rem_dif[LEN_W:0] : rem_sh[LEN_W:0];
			root_q <= {root_q[LEN_W-2:0], fits};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(LEN_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule

`default_nettype wire

### rtl/tgr_back.sv
// tgr_back: per-triangle sequencer with shared multiplier, divider and root
// classifies, computes gradients, area and targets, drives the result register
// depends on tgr_pkg, tgr_div, tgr_sqrt
`default_nettype none

module tgr_back import tgr_pkg::*; #(
	parameter int FRAC_BITS   = FRAC_BITS_DEF,
	parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [31:0] cfg_wdata,
	input  wire logic        ent_valid,
	input  wire tgr_ent_t    ent,
	output logic             pop,
	output logic             out_valid,
	input  wire logic        out_stall,
	output tgr_out_t         out_word
);

	localparam int S   = 32 + FRAC_BITS;
	localparam int DW  = 35 + S;
	localparam int ASH = 31 - 2 * FRAC_BITS;
	localparam int SHL = (ASH >= 0) ? ASH : 0;
	localparam int SHR = (ASH < 0) ? -ASH : 0;
	localparam int AW  = DEN_W + SHL;

	typedef enum logic [4:0] {
		ST_IDLE, ST_MAC, ST_SQL, ST_SQL_W, ST_CHKL, ST_DX, ST_DX_W, ST_SQY, ST_SQY_W,
		ST_CHKY, ST_DIV, ST_DIV_W, ST_TXD, ST_TYD, ST_ROWX, ST_ROWY, ST_DEG
	} state_t;

	typedef enum logic [2:0] {
		PR_E2, PR_DOT, PR_F2X, PR_DEN, PR_TX, PR_TY
	} prog_t;

	state_t                   state_q;
	state_t                   ret_q;
	prog_t                    prog_q;
	logic [2:0]               cnt_q;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [PROD_W-1:0] prod_q;
	logic                     pv_q;
	logic                     psh_q;
	logic                     psub_q;
	tgr_ent_t                 ent_q;
	logic [LEN_W-1:0]         l_q;
	logic [LEN_W-1:0]         y_q;
	logic signed [MUL_W-1:0]  x2_q;
	logic [DEN_W-1:0]         den_q;
	logic signed [63:0]       gx0_q;
	logic signed [63:0]       gx1_q;
	logic signed [63:0]       gy0_q;
	logic signed [63:0]       gy1_q;
	logic signed [63:0]       gy2_q;
	logic signed [63:0]       tx_q;
	logic [62:0]              area_q;
	logic [1:0]               dsel_q;
	logic [COUNT_WIDTH-1:0]   vcnt_q;
	logic [COUNT_WIDTH-1:0]   scnt_q;
	logic [31:0]              min_len_q;
	logic                     out_valid_q;
	tgr_out_t                 out_q;

	logic signed [MUL_W-1:0]  op_a;
	logic signed [MUL_W-1:0]  op_b;
	logic                     op_sh;
	logic                     op_sub;
	logic [2:0]               prog_len;
	logic signed [63:0]       gk;
	logic signed [31:0]       pk;
	logic signed [ACC_W-1:0]  pext;
	logic [ACC_W-1:0]         acc_mag;
	logic signed [MUL_W:0]    xl_dif;
	logic [MUL_W-1:0]         xl_mag;
	logic [MUL_W-1:0]         x2_mag;
	logic                     acc_pos;
	logic                     out_free;
	logic                     out_load;
	logic [AW-1:0]            area_full;

	logic                     div_start;
	logic [DW-1:0]            div_num;
	logic [DEN_W-1:0]         div_dvs;
	logic                     div_done;
	logic [DW-1:0]            div_quo;
	logic                     sq_start;
	logic                     sq_done;
	logic [LEN_W-1:0]         sq_root;

	function automatic logic signed [63:0] sat_quo(input logic [DW-1:0] q, input logic neg);
		logic [63:0] m;
		m = {1'b0, q[62:0]};
		if (q[DW-1:63] != '0) begin
			return neg ? SAT_MIN : SAT_MAX;
		end
		return neg ? -$signed(m) : $signed(m);
	endfunction

	function automatic logic signed [63:0] sat_acc(input logic signed [ACC_W-1:0] a);
		logic signed [ACC_W-1:0] t;
		t = a >>> FRAC_BITS;
		if ((&t[ACC_W-1:63]) || !(|t[ACC_W-1:63])) begin
			return t[63:0];
		end
		return t[ACC_W-1] ? SAT_MIN : SAT_MAX;
	endfunction

	// mac program operands
	always_comb begin
		gk = '0;
		pk = '0;
		unique case (cnt_q[2:1])
			2'd0: begin
				gk = (prog_q == PR_TX) ? gx0_q : gy0_q;
				pk = ent_q.p0;
			end
			2'd1: begin
				gk = (prog_q == PR_TX) ? gx1_q : gy1_q;
				pk = ent_q.p1;
			end
			2'd2: begin
				gk = (prog_q == PR_TX) ? 64'sd0 : gy2_q;
				pk = ent_q.p2;
			end
			default: begin
				gk = '0;
				pk = '0;
			end
		endcase
	end

	always_comb begin
		op_a     = '0;
		op_b     = '0;
		op_sh    = 1'b0;
		op_sub   = 1'b0;
		prog_len = 3'd3;
		unique case (prog_q)
			PR_E2, PR_DOT, PR_F2X: begin
				prog_len = (prog_q == PR_F2X) ? 3'd4 : 3'd3;
				case (cnt_q)
					3'd0: begin
						op_a = MUL_W'(ent_q.e0);
						op_b = (prog_q == PR_DOT) ? MUL_W'(ent_q.e0) : MUL_W'(ent_q.e0);
					end
					3'd1: op_a = MUL_W'(ent_q.e1);
					3'd2: op_a = MUL_W'(ent_q.e2);
					default: begin
						op_a   = x2_q;
						op_sub = 1'b1;
					end
				endcase
				if (prog_q == PR_F2X) begin
					case (cnt_q)
						3'd0: op_a = MUL_W'(ent_q.f0);
						3'd1: op_a = MUL_W'(ent_q.f1);
						3'd2: op_a = MUL_W'(ent_q.f2);
						default: op_a = x2_q;
					endcase
				end
				case (cnt_q)
					3'd0: op_b = (prog_q == PR_E2) ? MUL_W'(ent_q.e0) :
						MUL_W'(ent_q.f0);
					3'd1: op_b = (prog_q == PR_E2) ? MUL_W'(ent_q.e1) :
						MUL_W'(ent_q.f1);
					3'd2: op_b = (prog_q == PR_E2) ? MUL_W'(ent_q.e2) :
						MUL_W'(ent_q.f2);
					default: op_b = x2_q;
				endcase
			end
			PR_DEN: begin
				prog_len = 3'd1;
				op_a     = $signed({1'b0, l_q});
				op_b     = $signed({1'b0, y_q});
			end
			PR_TX, PR_TY: begin
				prog_len = 3'd6;
				op_sh    = !cnt_q[0];
				op_a     = cnt_q[0] ? $signed({3'b000, gk[31:0]}) :
					MUL_W'($signed(gk[63:32]));
				op_b     = MUL_W'(pk);
			end
			default: prog_len = 3'd1;
		endcase
	end

	assign pext     = psh_q ? (ACC_W'(prod_q) <<< 32) : ACC_W'(prod_q);
	assign acc_mag  = acc_q[ACC_W-1] ? ACC_W'(-acc_q) : ACC_W'(acc_q);
	assign acc_pos  = !acc_q[ACC_W-1] && (acc_q != '0);
	assign xl_dif   = (MUL_W+1)'(x2_q) - $signed({2'b00, l_q});
	assign xl_mag   = xl_dif[MUL_W] ? MUL_W'(-xl_dif) : MUL_W'(xl_dif);
	assign x2_mag   = x2_q[MUL_W-1] ? MUL_W'(-x2_q) : MUL_W'(x2_q);
	assign out_free = !out_valid_q || !out_stall;
	assign out_load = out_free &&
		((state_q == ST_ROWX) || (state_q == ST_ROWY) || (state_q == ST_DEG));
	assign area_full = (AW'(acc_q[DEN_W-1:0]) << SHL) >> SHR;

	assign pop      = (state_q == ST_IDLE) && ent_valid;
	assign sq_start = (state_q == ST_SQL) || ((state_q == ST_SQY) && acc_pos);
	assign div_start = (state_q == ST_DX) || (state_q == ST_DIV);

	always_comb begin
		div_num = '0;
		div_dvs = DEN_W'(l_q);
		if (state_q == ST_DX) begin
			div_num = DW'(acc_mag[65:0]);
		end else begin
			case (dsel_q)
				2'd0: div_num = DW'(1) << S;
				2'd1: div_num = DW'(xl_mag) << S;
				2'd2: div_num = DW'(x2_mag) << S;
				default: div_num = DW'(1) << S;
			endcase
			case (dsel_q)
				2'd0: div_dvs = DEN_W'(l_q);
				2'd3: div_dvs = DEN_W'(y_q);
				default: div_dvs = den_q;
			endcase
		end
	end

	tgr_div #(.DW(DW)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_num),
		.divisor  (div_dvs),
		.done     (div_done),
		.quo      (div_quo)
	);

	tgr_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sq_start),
		.rad    (acc_q[RAD_W-1:0]),
		.done   (sq_done),
		.root   (sq_root)
	);

	// datapath registers
	always_ff @(posedge clk) begin
		if (pop) begin
			ent_q <= ent;
		end
		if (state_q == ST_MAC && cnt_q < prog_len) begin
			prod_q <= op_a * op_b;
			psh_q  <= op_sh;
			psub_q <= op_sub;
		end
		if (state_q == ST_SQL_W && sq_done) begin
			l_q <= sq_root;
		end
		if (state_q == ST_SQY) begin
			y_q <= '0;
		end
		if (state_q == ST_SQY_W && sq_done) begin
			y_q <= sq_root;
		end
		if (state_q == ST_DX_W && div_done) begin
			x2_q <= acc_q[ACC_W-1] ? -$signed(div_quo[MUL_W-1:0]) :
				$signed(div_quo[MUL_W-1:0]);
		end
		if (state_q == ST_DIV && dsel_q == 2'd0) begin
			den_q  <= acc_q[DEN_W-1:0];
			area_q <= (area_full[AW-1:63] != '0) ? 63'h7FFF_FFFF_FFFF_FFFF :
				area_full[62:0];
		end
		if (state_q == ST_DIV_W && div_done) begin
			case (dsel_q)
				2'd0: begin
					gx0_q <= sat_quo(div_quo, 1'b1);
					gx1_q <= sat_quo(div_quo, 1'b0);
				end
				2'd1: gy0_q <= sat_quo(div_quo, xl_dif[MUL_W]);
				2'd2: gy1_q <= sat_quo(div_quo, !x2_q[MUL_W-1] && (x2_q != '0));
				default: gy2_q <= sat_quo(div_quo, 1'b0);
			endcase
		end
		if (state_q == ST_TXD) begin
			tx_q <= sat_acc(acc_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ret_q       <= ST_IDLE;
			prog_q      <= PR_E2;
			cnt_q       <= '0;
			acc_q       <= '0;
			pv_q        <= 1'b0;
			dsel_q      <= '0;
			vcnt_q      <= '0;
			scnt_q      <= '0;
			min_len_q   <= 32'd1;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			if (cfg_we) begin
				min_len_q <= cfg_wdata;
			end
			if (out_valid_q && !out_stall && !out_load) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (ent_valid) begin
						prog_q  <= PR_E2;
						ret_q   <= ST_SQL;
						cnt_q   <= '0;
						acc_q   <= '0;
						pv_q    <= 1'b0;
						state_q <= ST_MAC;
					end
				end
				ST_MAC: begin
					pv_q <= (cnt_q < prog_len);
					if (pv_q) begin
						acc_q <= psub_q ? acc_q - pext : acc_q + pext;
					end
					cnt_q <= cnt_q + 3'd1;
					if (cnt_q == prog_len) begin
						state_q <= ret_q;
					end
				end
				ST_SQL: state_q <= ST_SQL_W;
				ST_SQL_W: begin
					if (sq_done) begin
						state_q <= ST_CHKL;
					end
				end
				ST_CHKL: begin
					if (l_q <= LEN_W'(min_len_q)) begin
						scnt_q  <= scnt_q + COUNT_WIDTH'(1);
						state_q <= ST_DEG;
					end else begin
						prog_q  <= PR_DOT;
						ret_q   <= ST_DX;
						cnt_q   <= '0;
						acc_q   <= '0;
						pv_q    <= 1'b0;
						state_q <= ST_MAC;
					end
				end
				ST_DX: state_q <= ST_DX_W;
				ST_DX_W: begin
					if (div_done) begin
						prog_q  <= PR_F2X;
						ret_q   <= ST_SQY;
						cnt_q   <= '0;
						acc_q   <= '0;
						pv_q    <= 1'b0;
						state_q <= ST_MAC;
					end
				end
				ST_SQY: state_q <= acc_pos ? ST_SQY_W : ST_CHKY;
				ST_SQY_W: begin
					if (sq_done) begin
						state_q <= ST_CHKY;
					end
				end
				ST_CHKY: begin
					if (y_q <= LEN_W'(min_len_q)) begin
						scnt_q  <= scnt_q + COUNT_WIDTH'(1);
						state_q <= ST_DEG;
					end else begin
						vcnt_q  <= vcnt_q + COUNT_WIDTH'(1);
						prog_q  <= PR_DEN;
						ret_q   <= ST_DIV;
						dsel_q  <= 2'd0;
						cnt_q   <= '0;
						acc_q   <= '0;
						pv_q    <= 1'b0;
						state_q <= ST_MAC;
					end
				end
				ST_DIV: state_q <= ST_DIV_W;
				ST_DIV_W: begin
					if (div_done) begin
						if (dsel_q == 2'd3) begin
							prog_q  <= PR_TX;
							ret_q   <= ST_TXD;
							cnt_q   <= '0;
							acc_q   <= '0;
							pv_q    <= 1'b0;
							state_q <= ST_MAC;
						end else begin
							dsel_q  <= dsel_q + 2'd1;
							state_q <= ST_DIV;
						end
					end
				end
				ST_TXD: begin
					prog_q  <= PR_TY;
					ret_q   <= ST_TYD;
					cnt_q   <= '0;
					acc_q   <= '0;
					pv_q    <= 1'b0;
					state_q <= ST_MAC;
				end
				ST_TYD: state_q <= ST_ROWX;
				ST_ROWX: begin
					if (out_free) begin
						out_valid_q         <= 1'b1;
						out_q.axis          <= 1'b0;
						out_q.grad_a        <= gx0_q;
						out_q.grad_b        <= gx1_q;
						out_q.grad_c        <= '0;
						out_q.row_target    <= tx_q;
						out_q.tri_area      <= area_q;
						out_q.degenerate    <= 1'b0;
						out_q.last          <= 1'b0;
						out_q.valid_total   <= 32'(vcnt_q);
						out_q.skipped_total <= 32'(scnt_q);
						state_q             <= ST_ROWY;
					end
				end
				ST_ROWY: begin
					if (out_free) begin
						out_valid_q         <= 1'b1;
						out_q.axis          <= 1'b1;
						out_q.grad_a        <= gy0_q;
						out_q.grad_b        <= gy1_q;
						out_q.grad_c        <= gy2_q;
						out_q.row_target    <= sat_acc(acc_q);
						out_q.tri_area      <= area_q;
						out_q.degenerate    <= 1'b0;
						out_q.last          <= 1'b1;
						out_q.valid_total   <= 32'(vcnt_q);
						out_q.skipped_total <= 32'(scnt_q);
						state_q             <= ST_IDLE;
					end
				end
				ST_DEG: begin
					if (out_free) begin
						out_valid_q         <= 1'b1;
						out_q.axis          <= 1'b0;
						out_q.grad_a        <= '0;
						out_q.grad_b        <= '0;
						out_q.grad_c        <= '0;
						out_q.row_target    <= '0;
						out_q.tri_area      <= '0;
						out_q.degenerate    <= 1'b1;
						out_q.last          <= 1'b1;
						out_q.valid_total   <= 32'(vcnt_q);
						out_q.skipped_total <= 32'(scnt_q);
						state_q             <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_q;

endmodule

`default_nettype wire

### rtl/triangle_gradient_rows_unit.sv
// triangle_gradient_rows_unit: top level, front queue plus back sequencer
// depends on tgr_pkg, tgr_front, tgr_back
//
//   channel   dir   handshake            payload
//   in        in    in_valid / in_stall   in_word   (tgr_in_t, one triangle)
//   out       out   out_valid / out_stall out_word  (tgr_out_t, one row)
//   cfg       in    cfg_we                cfg_wdata (min_length)
//
// a triangle's time in the back is set mostly by the shared one-bit-per-cycle divider (five divisions),
// and out_stall can hold it further
// a degenerate triangle leaves early, at the edge check on a short first edge, else at the height check
// the front queue holds two triangles, so words are taken while the back works
// reset clears counters, queue and the result register; min_length resets to 1
`default_nettype none

module triangle_gradient_rows_unit import tgr_pkg::*; #(
	parameter int FRAC_BITS   = FRAC_BITS_DEF,
	parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire tgr_in_t     in_word,
	output logic             out_valid,
	input  wire logic        out_stall,
	output tgr_out_t         out_word,
	input  wire logic        cfg_we,
	input  wire logic [31:0] cfg_wdata
);

	logic     ent_valid;
	tgr_ent_t ent;
	logic     pop;

	tgr_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_word   (in_word),
		.ent_valid (ent_valid),
		.ent       (ent),
		.pop       (pop)
	);

	tgr_back #(
		.FRAC_BITS   (FRAC_BITS),
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.ent_valid (ent_valid),
		.ent       (ent),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_word  (out_word)
	);

endmodule

`default_nettype wire

### tb/triangle_gradient_rows_unit_tb.sv
// triangle_gradient_rows_unit_tb: self-checking bench for the triangle gradient rows unit
// predicts basis gradient rows, area, targets and counters per triangle, checks every row
// depends on tgr_pkg and triangle_gradient_rows_unit
`timescale 1ns / 1ps

module triangle_gradient_rows_unit_tb;
	import tgr_pkg::*;

	localparam int GRAD_SHIFT = 32 + FRAC_BITS_DEF;
	localparam int TGT_SHIFT  = FRAC_BITS_DEF;
	localparam int WATCH_LIMIT = 20000;
	localparam logic [31:0] LEN_MAX = 32'hFFFF_FFFF;

	typedef logic signed [129:0] wide_t;

	function automatic wide_t sx32(logic [31:0] v);
		return {{98{v[31]}}, v};
	endfunction

	function automatic wide_t sx64(logic [63:0] v);
		return {{66{v[63]}}, v};
	endfunction

	function automatic logic [63:0] isqrt(wide_t n);
		logic [63:0] r;
		wide_t t;
		r = '0;
		for (int b = 63; b >= 0; b--) begin
			t = {66'b0, r | (64'b1 << b)};
			if (t * t <= n) r = r | (64'b1 << b);
		end
		return r;
	endfunction

	function automatic logic [63:0] sat64(wide_t v);
		if (v > sx64(SAT_MAX)) return SAT_MAX;
		if (v < sx64(SAT_MIN)) return SAT_MIN;
		return v[63:0];
	endfunction

	function automatic logic [63:0] scaled_quot(wide_t n, wide_t den);
		logic [129:0] mag, q;
		mag = n < 0 ? -n : n;
		q = (mag << GRAD_SHIFT) / den;
		return sat64(n < 0 ? -$signed(q) : $signed(q));
	endfunction

	class row_scoreboard;
		tgr_out_t rows_due[$];
		logic [31:0] min_len;
		logic [31:0] valid_cnt;
		logic [31:0] skip_cnt;
		int errors;

		function new();
			min_len = 32'd1;
			valid_cnt = '0;
			skip_cnt = '0;
			errors = 0;
		endfunction

		task report(string what, logic [63:0] got, logic [63:0] want);
			errors++;
			$display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
		endtask

		function void note_triangle(tgr_in_t w);
			wide_t e[3], f[3], p[3], g[2][3];
			wide_t sq, dot, mag, x2, x2sq, e2f, lw, yw, den, ar, acc;
			logic [63:0] l, y;
			tgr_out_t r;
			e[0] = sx32(w.bx) - sx32(w.ax);
			e[1] = sx32(w.by_coord) - sx32(w.ay);
			e[2] = sx32(w.bz) - sx32(w.az);
			f[0] = sx32(w.cx) - sx32(w.ax);
			f[1] = sx32(w.cy) - sx32(w.ay);
			f[2] = sx32(w.cz) - sx32(w.az);
			p[0] = sx32(w.prior_a);
			p[1] = sx32(w.prior_b);
			p[2] = sx32(w.prior_c);
			sq = e[0] * e[0] + e[1] * e[1] + e[2] * e[2];
			l = isqrt(sq);
			lw = {66'b0, l};
			y = '0;
			x2 = '0;
			if (l > {32'b0, min_len}) begin
				dot = e[0] * f[0] + e[1] * f[1] + e[2] * f[2];
				mag = dot < 0 ? -dot : dot;
				mag = $unsigned(mag) / $unsigned(lw);
				x2 = {82'b0, mag[47:0]};
				if (dot < 0) x2 = -x2;
				x2sq = x2 * x2;
				e2f = f[0] * f[0] + f[1] * f[1] + f[2] * f[2];
				y = e2f > x2sq ? isqrt(e2f - x2sq) : '0;
			end
			r = '0;
			if (l <= {32'b0, min_len} || y <= {32'b0, min_len}) begin
				skip_cnt++;
				r.degenerate = 1'b1;
				r.last = 1'b1;
				r.valid_total = valid_cnt;
				r.skipped_total = skip_cnt;
				rows_due.push_back(r);
				return;
			end
			valid_cnt++;
			yw = {66'b0, y};
			den = lw * yw;
			g[0][0] = sx64(scaled_quot(-1, lw));
			g[0][1] = sx64(scaled_quot(1, lw));
			g[0][2] = '0;
			g[1][0] = sx64(scaled_quot(x2 - lw, den));
			g[1][1] = sx64(scaled_quot(-x2, den));
			g[1][2] = sx64(scaled_quot(1, yw));
			ar = den >>> 1;
			for (int k = 0; k < 2; k++) begin
				acc = g[k][0] * p[0] + g[k][1] * p[1] + g[k][2] * p[2];
				r.axis = k[0];
				r.grad_a = g[k][0][63:0];
				r.grad_b = g[k][1][63:0];
				r.grad_c = g[k][2][63:0];
				r.row_target = sat64(acc >>> TGT_SHIFT);
				r.tri_area = ar > sx64(SAT_MAX) ? SAT_MAX[62:0] : ar[62:0];
				r.degenerate = 1'b0;
				r.last = k[0];
				r.valid_total = valid_cnt;
				r.skipped_total = skip_cnt;
				rows_due.push_back(r);
			end
		endfunction

		task check_row(tgr_out_t got);
			tgr_out_t want;
			if (rows_due.size() == 0) begin
				report("unexpected word", 64'(got.row_target), 64'b0);
				return;
			end
			want = rows_due.pop_front();
			if (got.axis !== want.axis) report("axis", 64'(got.axis), 64'(want.axis));
			if (got.grad_a !== want.grad_a) report("grad_a", got.grad_a, want.grad_a);
			if (got.grad_b !== want.grad_b) report("grad_b", got.grad_b, want.grad_b);
			if (got.grad_c !== want.grad_c) report("grad_c", got.grad_c, want.grad_c);
			if (got.row_target !== want.row_target)
				report("row_target", got.row_target, want.row_target);
			if (got.tri_area !== want.tri_area)
				report("tri_area", 64'(got.tri_area), 64'(want.tri_area));
			if (got.degenerate !== want.degenerate)
				report("degenerate", 64'(got.degenerate), 64'(want.degenerate));
			if (got.last !== want.last) report("last", 64'(got.last), 64'(want.last));
			if (got.valid_total !== want.valid_total)
				report("valid_total", 64'(got.valid_total), 64'(want.valid_total));
			if (got.skipped_total !== want.skipped_total)
				report("skipped_total", 64'(got.skipped_total), 64'(want.skipped_total));
		endtask
	endclass

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	tgr_in_t     in_word;
	logic        out_valid;
	logic        out_stall;
	tgr_out_t    out_word;
	logic        cfg_we;
	logic [31:0] cfg_wdata;

	row_scoreboard sb;
	bit quiet;
	int idle_cycles;
	int stall_left;

	triangle_gradient_rows_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_word   (in_word),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_word  (out_word),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) sb.note_triangle(in_word);
			if (out_valid && !out_stall) sb.check_row(out_word);
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
			else idle_cycles++;
			if (idle_cycles >= WATCH_LIMIT) begin
				$display("FAIL triangle_gradient_rows_unit");
				$finish;
			end
		end
	end

	// receiver stall bursts
	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			out_stall <= 1'b1;
		end else if (!quiet && $urandom_range(0, 5) == 0) begin
			stall_left = $urandom_range(0, 6);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	task automatic send_triangle(tgr_in_t w);
		in_valid <= 1'b1;
		in_word <= w;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
	endtask

	task automatic send_gapped(tgr_in_t w);
		if (!quiet && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(negedge clk);
		end
		send_triangle(w);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (sb.rows_due.size() != 0) @(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	task automatic write_min_len(logic [31:0] v);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		sb.min_len = v;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [31:0] coord(int scale);
		return 32'($signed($urandom) >>> (31 - scale));
	endfunction

	function automatic tgr_in_t make_triangle(logic [31:0] d [12]);
		tgr_in_t w;
		w = {d[0], d[1], d[2], d[3], d[4], d[5], d[6], d[7], d[8], d[9], d[10], d[11]};
		return w;
	endfunction

	function automatic tgr_in_t random_triangle();
		logic [31:0] d [12];
		int kind, s;
		logic [31:0] step [3];
		kind = $urandom_range(0, 9);
		s = $urandom_range(2, 30);
		for (int i = 0; i < 12; i++) d[i] = coord(s);
		case (kind)
			6: begin
				for (int i = 0; i < 9; i++) d[i] = $urandom;
			end
			7: begin
				for (int i = 0; i < 3; i++) begin
					step[i] = coord(s > 20 ? 20 : s);
					d[3 + i] = d[i] + step[i];
					d[6 + i] = d[i] + step[i] * $urandom_range(0, 3);
				end
			end
			8: begin
				for (int i = 0; i < 3; i++) d[6 + i] = d[3 * $urandom_range(0, 1) + i];
			end
			9: begin
				for (int i = 3; i < 9; i++) d[i] = d[i % 3] + 32'($urandom_range(0, 4)) - 32'd2;
			end
			default: ;
		endcase
		if ($urandom_range(0, 7) == 0) begin
			for (int i = 9; i < 12; i++) d[i] = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
		end else if ($urandom_range(0, 1) == 0) begin
			for (int i = 9; i < 12; i++) d[i] = $urandom;
		end
		return make_triangle(d);
	endfunction

	task automatic directed_triangles();
		logic [31:0] d [12];
		localparam logic [31:0] ONE = 32'h0001_0000;
		// unit right triangle
		d = '{0, 0, 0, ONE, 0, 0, 0, ONE, 0, ONE, 32'h8000_0000, 32'h7FFF_FFFF};
		send_triangle(make_triangle(d));
		// all zero
		d = '{default: 32'h0};
		send_triangle(make_triangle(d));
		// opposite extremes, huge triangle
		d = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
			32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF};
		send_triangle(make_triangle(d));
		// obtuse, foot of vertex 2 behind vertex 0
		d = '{ONE, ONE, 0, 3 * ONE, ONE, 0, -32'(ONE), 5 * ONE, ONE,
			32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
		send_triangle(make_triangle(d));
		// colinear
		d = '{0, 0, 0, ONE, ONE, ONE, 2 * ONE, 2 * ONE, 2 * ONE, ONE, ONE, ONE};
		send_triangle(make_triangle(d));
		// tiny, lengths of two raw units
		d = '{5, 5, 5, 7, 5, 5, 5, 7, 5, ONE, 2 * ONE, 3 * ONE};
		send_triangle(make_triangle(d));
		// lengths of exactly one raw unit
		d = '{0, 0, 0, 1, 0, 0, 0, 1, 0, 32'hFFFF_FFFF, 1, 0};
		send_triangle(make_triangle(d));
		// tiny area, tri_area of two raw units
		d = '{0, 0, 0, 2, 0, 0, 0, 2, 0, ONE, ONE, ONE};
		send_triangle(make_triangle(d));
		// very thin sliver with a long base
		d = '{32'h8000_0000, 0, 0, 32'h7FFF_FFFF, 0, 0, 0, 3, 0,
			32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF};
		send_triangle(make_triangle(d));
		// vertex 2 equal to vertex 1
		d = '{0, 0, 0, ONE, 0, 0, ONE, 0, 0, ONE, ONE, ONE};
		send_triangle(make_triangle(d));
		// all ones bit pattern
		d = '{default: 32'hFFFF_FFFF};
		d[3] = 32'h0000_FFFF;
		d[7] = 32'h5555_5555;
		send_triangle(make_triangle(d));
		for (int i = 0; i < 6; i++) send_gapped(random_triangle());
	endtask

	task automatic random_phase(int count);
		for (int i = 0; i < count; i++) send_gapped(random_triangle());
	endtask

	initial begin
		sb = new();
		quiet = 1'b0;
		idle_cycles = 0;
		stall_left = 0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_word = '0;
		out_stall = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		directed_triangles();
		drain();
		write_min_len(32'd0);
		directed_triangles();
		random_phase(130);
		drain();
		write_min_len(32'h0001_0000);
		random_phase(130);
		drain();
		write_min_len(LEN_MAX);
		random_phase(20);
		drain();
		write_min_len($urandom_range(2, 32'h0100_0000));
		random_phase(130);
		drain();
		write_min_len(32'd1);
		random_phase(160);
		quiet = 1'b1;
		random_phase(80);
		drain();
		repeat (50) @(negedge clk);
		if (sb.rows_due.size() != 0)
			sb.report("rows left over", 64'(sb.rows_due.size()), 64'b0);
		if (sb.errors == 0) begin
			$display("PASS triangle_gradient_rows_unit");
		end else begin
			$display("FAIL triangle_gradient_rows_unit");
		end
		$finish;
	end

endmodule
